// File: rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define EMGD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EMGD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/emgd_pkg.sv
package emgd_pkg;

  // Input item modes
  localparam logic [2:0] MODE_TICK      = 3'd0;
  localparam logic [2:0] MODE_TERM_BYTE = 3'd1;
  localparam logic [2:0] MODE_LINE_BYTE = 3'd2;
  localparam logic [2:0] MODE_LINE_ERR  = 3'd3;
  localparam logic [2:0] MODE_ONLINE    = 3'd4;

  // Result destinations
  localparam logic [1:0] DEST_LINE = 2'd0;
  localparam logic [1:0] DEST_TERM = 2'd1;
  localparam logic [1:0] DEST_CMD  = 2'd2;

  // Result events
  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_ESCAPE    = 2'd1;
  localparam logic [1:0] EV_NOCARRIER = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_GUARD_TICKS  = 2'd0;
  localparam logic [1:0] CFG_ESCAPE_CHAR  = 2'd1;
  localparam logic [1:0] CFG_ESCAPE_COUNT = 2'd2;

  // Configuration reset values
  localparam logic [15:0] GUARD_TICKS_RST  = 16'd50;
  localparam logic [7:0]  ESCAPE_CHAR_RST  = 8'd43;
  localparam logic [2:0]  ESCAPE_COUNT_RST = 3'd3;

  localparam int unsigned CFG_DATA_W = 16;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
  } emgd_in_t;

  typedef struct packed {
    logic [1:0] destination;
    logic [7:0] out_byte;
    logic [1:0] event_code;
    logic       last_of_run;
  } emgd_out_t;

  typedef struct packed {
    logic [15:0] guard_ticks;
    logic [7:0]  escape_char;
    logic [2:0]  escape_count;
  } emgd_cfg_t;

  // One command: rel_cnt escape bytes to the line, then one final result
  typedef struct packed {
    logic [2:0] rel_cnt;
    logic [7:0] esc_byte;
    logic [1:0] destination;
    logic [7:0] out_byte;
    logic [1:0] event_code;
  } emgd_cmd_t;

endpackage

// File: rtl/core/modem_escape_guard_detector.sv
// Escape guard detector for an online data pump. Terminal bytes go to the
// line and line bytes to the terminal; escape characters that follow a guard
// silence are held and, if exactly escape_count of them are followed by
// another guard silence (counted in tick items), an escape event for the
// command processor is reported and the block returns to command mode. A line
// error reports carrier loss. A front stage takes one item per cycle when the
// queue has room and updates the guard state; a two-entry command queue feeds
// a back stage that delivers one result per cycle from a registered output
// when not stalled. An item that releases held escapes yields held count plus
// one results (up to 8); other items sustain one per cycle when not stalled.
// The back stage's single output register sets that rate. Configuration is
// written by the user while no item is in flight; no logic here enforces it.
module modem_escape_guard_detector import emgd_pkg::*; #(
  parameter int unsigned TICK_COUNTER_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  emgd_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output emgd_out_t             out_data_o
);

  emgd_cfg_t cfg_q;
  emgd_cmd_t push_cmd;
  emgd_cmd_t pop_cmd;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.guard_ticks  <= GUARD_TICKS_RST;
      cfg_q.escape_char  <= ESCAPE_CHAR_RST;
      cfg_q.escape_count <= ESCAPE_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GUARD_TICKS:  cfg_q.guard_ticks  <= cfg_wdata_i[15:0];
        CFG_ESCAPE_CHAR:  cfg_q.escape_char  <= cfg_wdata_i[7:0];
        CFG_ESCAPE_COUNT: cfg_q.escape_count <= cfg_wdata_i[2:0];
        default: begin
        end
      endcase
    end
  end

  emgd_front #(
    .TICK_COUNTER_WIDTH(TICK_COUNTER_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  emgd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (empty)
  );

  emgd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/core/emgd_front.sv
module emgd_front import emgd_pkg::*; #(
  parameter int unsigned TICK_COUNTER_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  emgd_cfg_t cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  emgd_in_t  in_data_i,
  output logic      push_o,
  output emgd_cmd_t cmd_o,
  input  logic      full_i
);

  localparam int unsigned CmpW = (TICK_COUNTER_WIDTH > 16) ? TICK_COUNTER_WIDTH : 16;

  logic                          online_q, online_d;
  logic                          guard_q, guard_d;
  logic [2:0]                    held_q, held_d;
  logic [TICK_COUNTER_WIDTH-1:0] sil_q, sil_d;
  logic [TICK_COUNTER_WIDTH-1:0] sil_inc;
  logic                          accept;
  logic                          is_esc;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // Saturating silence count and escape match
  assign sil_inc = (sil_q != {TICK_COUNTER_WIDTH{1'b1}}) ?
                   sil_q + TICK_COUNTER_WIDTH'(1) : sil_q;
  assign is_esc  = (in_data_i.data_byte == cfg_i.escape_char);

  // Classify the item and update the guard state
  always_comb begin
    online_d = online_q;
    guard_d  = guard_q;
    held_d   = held_q;
    sil_d    = sil_q;
    push_o   = 1'b0;
    cmd_o    = '{rel_cnt: 3'd0, esc_byte: cfg_i.escape_char, destination: DEST_LINE,
                 out_byte: in_data_i.data_byte, event_code: EV_NONE};
    if (accept) begin
      if (!online_q) begin
        if (in_data_i.mode == MODE_ONLINE) begin
          online_d = 1'b1;
          guard_d  = 1'b0;
          held_d   = 3'd0;
          sil_d    = '0;
        end
      end else begin
        case (in_data_i.mode)
          MODE_TICK: begin
            sil_d = sil_inc;
            if (!guard_q && (CmpW'(sil_inc) >= CmpW'(cfg_i.guard_ticks))) begin
              guard_d = 1'b1;
              if (held_q != 3'd0 && held_q == cfg_i.escape_count) begin
                held_d            = 3'd0;
                online_d          = 1'b0;
                push_o            = 1'b1;
                cmd_o.destination = DEST_CMD;
                cmd_o.out_byte    = 8'd0;
                cmd_o.event_code  = EV_ESCAPE;
              end
            end
          end
          MODE_TERM_BYTE: begin
            if (is_esc && (held_q != 3'd0 || guard_q) && held_q < cfg_i.escape_count) begin
              held_d = held_q + 3'd1;
            end else begin
              // held escapes go first, then this byte
              push_o        = 1'b1;
              cmd_o.rel_cnt = held_q;
              held_d        = 3'd0;
            end
            guard_d = 1'b0;
            sil_d   = '0;
          end
          MODE_LINE_BYTE: begin
            push_o            = 1'b1;
            cmd_o.destination = DEST_TERM;
          end
          MODE_LINE_ERR: begin
            held_d            = 3'd0;
            online_d          = 1'b0;
            push_o            = 1'b1;
            cmd_o.destination = DEST_CMD;
            cmd_o.out_byte    = 8'd0;
            cmd_o.event_code  = EV_NOCARRIER;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q <= 1'b0;
      guard_q  <= 1'b0;
      held_q   <= 3'd0;
      sil_q    <= '0;
    end else begin
      online_q <= online_d;
      guard_q  <= guard_d;
      held_q   <= held_d;
      sil_q    <= sil_d;
    end
  end

endmodule

// File: rtl/core/emgd_fifo.sv
module emgd_fifo import emgd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  emgd_cmd_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output emgd_cmd_t pop_data_o,
  output logic      empty_o
);

  emgd_cmd_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QUEUE_PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QUEUE_PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QUEUE_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/emgd_back.sv
module emgd_back import emgd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  emgd_cmd_t cmd_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output emgd_out_t out_data_o
);

  logic       out_valid_q, out_valid_d;
  emgd_out_t  out_q, out_d;
  logic [2:0] idx_q, idx_d;
  logic       load;

  assign load        = !empty_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Walk a command: held escapes first, then the final result
  always_comb begin
    idx_d       = idx_q;
    pop_o       = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      out_valid_d = 1'b1;
      if (idx_q != cmd_i.rel_cnt) begin
        out_d = '{destination: DEST_LINE, out_byte: cmd_i.esc_byte,
                  event_code: EV_NONE, last_of_run: 1'b0};
        idx_d = idx_q + 3'd1;
      end else begin
        out_d = '{destination: cmd_i.destination, out_byte: cmd_i.out_byte,
                  event_code: cmd_i.event_code, last_of_run: 1'b1};
        idx_d = 3'd0;
        pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 3'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// File: rtl/core/emgd_checker.sv
`include "assert_macros.svh"

module emgd_checker import emgd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input emgd_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input emgd_out_t out_data_o
);

  // Stalled input item holds
  `EMGD_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o,
                    in_valid_i && $stable(in_data_i), "stalled item changed")

  // Stalled result holds
  `EMGD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(out_data_o), "stalled result changed")

  // Events always close their item
  `EMGD_ASSERT_NOW(a_event_last, out_valid_o && out_data_o.event_code != EV_NONE,
                   out_data_o.last_of_run, "event result not last")

  // Only released escapes come before the last result
  `EMGD_ASSERT_NOW(a_release_line, out_valid_o && !out_data_o.last_of_run,
                   out_data_o.destination == DEST_LINE && out_data_o.event_code == EV_NONE,
                   "early result is not a line byte")

  // Command processor results carry an event and no byte
  `EMGD_ASSERT_NOW(a_cmd_event, out_valid_o && out_data_o.destination == DEST_CMD,
                   out_data_o.event_code != EV_NONE && out_data_o.out_byte == 8'd0,
                   "command result without event")

endmodule

bind modem_escape_guard_detector emgd_checker u_emgd_checker (.*);
